### rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

	localparam int SLOT_W  = 3;
	localparam int FC_W    = 4;
	localparam int TOTAL_W = 32;

	localparam logic [FC_W-1:0]    FC_RESET  = 4'd8;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_DECIDE = 4'b1000
	} lrupr_state_t;

	// Control from the sequencer to the scan unit
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage

### rtl/lrupr_rank.sv
// Per-frame recency ranks (0 = most recent) with the registered touch update.
module lrupr_rank #(
	parameter int FRAMES = 8,
	parameter int IW     = 3,
	parameter int CW     = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          touch_en,
	input  logic [IW-1:0] touch_slot,
	input  logic [CW-1:0] touch_cutoff,
	input  logic [CW-1:0] touch_count,
	input  logic [IW-1:0] rd_idx,
	output logic [IW-1:0] rd_rank
);

	logic [IW-1:0] rank_q [FRAMES];

	assign rd_rank = rank_q[rd_idx];

	// Touched slot goes to rank 0; younger used slots age by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRAMES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (touch_en) begin
			for (int j = 0; j < FRAMES; j++) begin
				if (IW'(j) == touch_slot) begin
					rank_q[j] <= '0;
				end else if (CW'(j) < touch_count && CW'(rank_q[j]) < touch_cutoff) begin
					rank_q[j] <= IW'(rank_q[j] + 1'b1);
				end
			end
		end
	end

endmodule

### rtl/lrupr_scan.sv
// Shared compare unit: one frame per step, page match and oldest-rank search.
module lrupr_scan #(
	parameter int IW = 3,
	parameter int PW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrupr_pkg::scan_ctl_t   ctl,
	input  logic [IW-1:0]          idx,
	input  logic [PW-1:0]          page_rd,
	input  logic [IW-1:0]          rank_rd,
	input  logic [PW-1:0]          key,
	output logic                   match,
	output logic [IW-1:0]          match_idx,
	output logic [IW-1:0]          match_rank,
	output logic [IW-1:0]          old_idx,
	output logic [PW-1:0]          old_page
);
	import lrupr_pkg::*;

	logic          match_q;
	logic [IW-1:0] match_idx_q;
	logic [IW-1:0] match_rank_q;
	logic [IW-1:0] old_rank_q;
	logic [IW-1:0] old_idx_q;
	logic [PW-1:0] old_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.step && !match_q && page_rd == key) begin
			match_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			old_rank_q <= '0;
			old_idx_q  <= '0;
		end else if (ctl.step) begin
			if (!match_q && page_rd == key) begin
				match_idx_q  <= idx;
				match_rank_q <= rank_rd;
			end
			// strictly greater keeps the lowest slot on ties; slot 0 is the default
			if (idx == '0 || rank_rd > old_rank_q) begin
				old_rank_q <= rank_rd;
				old_idx_q  <= idx;
				old_page_q <= page_rd;
			end
		end
	end

	assign match      = match_q;
	assign match_idx  = match_idx_q;
	assign match_rank = match_rank_q;
	assign old_idx    = old_idx_q;
	assign old_page   = old_page_q;

endmodule

### rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: sequencer, page memory, output register.
//
// Each accepted page reference is looked up among the resident frames by a
// single compare unit that walks the page memory one slot per cycle. The same
// walk finds the least recently used slot (lowest slot on ties), so a hit, a
// fill of the next empty frame or a replacement is settled in the decide step
// after it, and the recency ranks of all frames are updated together there. An
// item passes through the scan over the frames in use, a drain step and the
// decide step before the block is idle again; with no frame filled yet the
// scan and drain are skipped. The decide step waits while the previous result
// is still held in the output register. in_ready is high only in the idle
// state. Results sit in an output register, so a new item may be accepted
// while the previous result waits for out_ready. frame_count may be written
// only while the block is idle; 0 acts as 1 and values above FRAMES act as
// FRAMES. Lowering it never empties a frame. fault_total saturates at its
// maximum. No clearing pass runs after reset: the scan only compares slots
// already filled.
module lru_page_replacement #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frame_count_we,
	input  logic [lrupr_pkg::FC_W-1:0]   frame_count_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [PAGE_BITS-1:0]         page,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [lrupr_pkg::SLOT_W-1:0] slot,
	output logic                         evicted_valid,
	output logic [PAGE_BITS-1:0]         evicted_page,
	output logic [lrupr_pkg::TOTAL_W-1:0] fault_total
);
	import lrupr_pkg::*;

	localparam int IW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // slot index
	localparam int CW   = $clog2(FRAMES + 1);                  // frame count
	localparam int LIMW = (CW > FC_W) ? CW : FC_W;

	lrupr_state_t         state_q;
	logic [FC_W-1:0]      frame_count_q;
	logic [CW-1:0]        used_q;
	logic [TOTAL_W-1:0]   fault_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [IW-1:0]        addr_q;

	// Page memory and its registered read
	logic [PAGE_BITS-1:0] frame_pages_q [FRAMES];
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic                 vld_s1;
	logic [IW-1:0]        idx_s1;

	// Output register
	logic                 out_valid_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [TOTAL_W-1:0]   total_q;

	scan_ctl_t            scan_ctl;
	logic                 sc_match;
	logic [IW-1:0]        sc_match_idx;
	logic [IW-1:0]        sc_match_rank;
	logic [IW-1:0]        sc_old_idx;
	logic [PAGE_BITS-1:0] sc_old_page;
	logic [IW-1:0]        rank_rd;

	logic                 accept;
	logic                 do_decide;
	logic [CW-1:0]        limit;
	logic                 fill;
	logic [IW-1:0]        sel_slot;
	logic [CW-1:0]        used_inc;
	logic [CW-1:0]        touch_cutoff;
	logic [CW-1:0]        touch_count;
	logic [TOTAL_W-1:0]   fault_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign do_decide = (state_q == ST_DECIDE) && (!out_valid_q || out_ready);

	// Effective frame limit, clamped to 1..FRAMES
	always_comb begin
		if (frame_count_q == '0) begin
			limit = CW'(1);
		end else if (LIMW'(frame_count_q) > LIMW'(FRAMES)) begin
			limit = CW'(FRAMES);
		end else begin
			limit = CW'(frame_count_q);
		end
	end

	assign used_inc = CW'(used_q + 1'b1);
	assign fill     = !sc_match && (used_q < limit);

	always_comb begin
		if (sc_match) begin
			sel_slot     = sc_match_idx;
			touch_cutoff = CW'(sc_match_rank);
			touch_count  = used_q;
		end else if (fill) begin
			sel_slot     = IW'(used_q);
			touch_cutoff = used_inc;
			touch_count  = used_inc;
		end else begin
			sel_slot     = sc_old_idx;
			touch_cutoff = used_q;
			touch_count  = used_q;
		end
	end

	assign fault_next = (sc_match || fault_q == TOTAL_MAX) ? fault_q : fault_q + 1'b1;

	assign scan_ctl.clear = accept;
	assign scan_ctl.step  = vld_s1;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (accept) begin
						state_q <= (used_q != '0) ? ST_SCAN : ST_DECIDE;
					end
				end
				ST_SCAN: begin
					addr_q <= IW'(addr_q + 1'b1);
					if (CW'(addr_q) == CW'(used_q - 1'b1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (do_decide) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			page_q <= page;
		end
	end

	// Page memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_decide && !sc_match) begin
			frame_pages_q[sel_slot] <= page_q;
		end
		rd_page_s1 <= frame_pages_q[addr_q];
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FC_RESET;
			used_q        <= '0;
			fault_q       <= '0;
		end else begin
			if (frame_count_we) begin
				frame_count_q <= frame_count_wdata;
			end
			if (do_decide) begin
				fault_q <= fault_next;
				if (fill) begin
					used_q <= used_inc;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_decide) begin
			hit_q      <= sc_match;
			slot_q     <= SLOT_W'(sel_slot);
			ev_valid_q <= !sc_match && !fill;
			ev_page_q  <= (!sc_match && !fill) ? sc_old_page : '0;
			total_q    <= fault_next;
		end
	end

	lrupr_scan #(
		.IW (IW),
		.PW (PAGE_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (idx_s1),
		.page_rd    (rd_page_s1),
		.rank_rd    (rank_rd),
		.key        (page_q),
		.match      (sc_match),
		.match_idx  (sc_match_idx),
		.match_rank (sc_match_rank),
		.old_idx    (sc_old_idx),
		.old_page   (sc_old_page)
	);

	lrupr_rank #(
		.FRAMES (FRAMES),
		.IW     (IW),
		.CW     (CW)
	) u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.touch_en     (do_decide),
		.touch_slot   (sel_slot),
		.touch_cutoff (touch_cutoff),
		.touch_count  (touch_count),
		.rd_idx       (idx_s1),
		.rd_rank      (rank_rd)
	);

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = total_q;

endmodule

### rtl/lrupr_checker.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
module lrupr_checker #(
	parameter int PAGE_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         hit,
	input logic [lrupr_pkg::SLOT_W-1:0] slot,
	input logic                         evicted_valid,
	input logic [PAGE_BITS-1:0]         evicted_page,
	input logic [lrupr_pkg::TOTAL_W-1:0] fault_total
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot)
			&& $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total))
		else $error("result changed while stalled");

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid)
		else $error("eviction reported on hit");

	// No eviction means a zero evicted page
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page not zero");

	// Fault count never goes down between shown results
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> fault_total >= $past(fault_total))
		else $error("fault total decreased");

	// The block is busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

endmodule

bind lru_page_replacement lrupr_checker #(
	.PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.slot          (slot),
	.evicted_valid (evicted_valid),
	.evicted_page  (evicted_page),
	.fault_total   (fault_total)
);

### tb/lru_page_replacement_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU page replacement block: directed cases, random references.
module lru_page_replacement_test;
	import lrupr_pkg::*;

	localparam int FRAME_SLOTS   = 8;
	localparam int PAGE_W        = 16;
	// Pause after all results have drained, before touching the config register.
	localparam int SETTLE_CYCLES = 16;
	// Cycles with no handshake on either side before the run is declared hung.
	// Worst honest case is a long sender gap plus a long receiver stall plus a
	// full scan plus a settle pause, well under this.
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 108;
	localparam int REPORT_MAX    = 10;

	typedef logic [PAGE_W-1:0] page_t;

	// One lookup result, in port order.
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		page_t              evicted_page;
		logic [TOTAL_W-1:0] fault_total;
	} lookup_t;

	logic               clk               = 1'b0;
	logic               arst_n            = 1'b0;
	logic               frame_count_we    = 1'b0;
	logic [FC_W-1:0]    frame_count_wdata = '0;
	logic               in_valid          = 1'b0;
	logic               in_ready;
	page_t              page              = '0;
	logic               out_valid;
	logic               out_ready         = 1'b0;
	logic               hit;
	logic [SLOT_W-1:0]  slot;
	logic               evicted_valid;
	page_t              evicted_page;
	logic [TOTAL_W-1:0] fault_total;

	lru_page_replacement #(
		.FRAMES    (FRAME_SLOTS),
		.PAGE_BITS (PAGE_W)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame_count_we    (frame_count_we),
		.frame_count_wdata (frame_count_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.page              (page),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hit               (hit),
		.slot              (slot),
		.evicted_valid     (evicted_valid),
		.evicted_page      (evicted_page),
		.fault_total       (fault_total)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the frame table.
	// resident_page holds the page in each filled slot, resident_rank the
	// age of that slot (0 = most recent, distinct among filled slots).
	// Slots fill from 0 upward and are never emptied.
	// ------------------------------------------------------------------
	page_t              resident_page [FRAME_SLOTS] = '{default: '0};
	int unsigned        resident_rank [FRAME_SLOTS] = '{default: 0};
	int unsigned        slots_filled  = 0;
	logic [TOTAL_W-1:0] faults_so_far = '0;
	logic [FC_W-1:0]    frame_limit   = FC_RESET;

	lookup_t            pending_lookups [$];

	int unsigned        refs_sent     = 0;
	int unsigned        results_seen  = 0;
	int unsigned        hits_seen     = 0;
	int unsigned        evicts_seen   = 0;
	int unsigned        bad_results   = 0;
	int unsigned        idle_cycles   = 0;
	int unsigned        ready_hold    = 0;
	int unsigned        ready_roll;
	lookup_t            got_lookup;
	lookup_t            want_lookup;

	// Make slot s the most recent; every other filled slot younger than
	// cutoff ages by one. Hits pass the slot's own rank, faults pass the
	// fill count, so all ranks stay distinct.
	function automatic void promote_slot(input int unsigned s, input int unsigned cutoff);
		for (int unsigned j = 0; j < slots_filled; j++) begin
			if (j != s && resident_rank[j] < cutoff)
				resident_rank[j]++;
		end
		resident_rank[s] = 0;
	endfunction

	// Work out the result of one reference and advance the shadow table.
	function automatic lookup_t predict_lookup(input page_t pg);
		lookup_t     r;
		int unsigned lim;
		int unsigned oldest;
		bit          found;
		r     = '0;
		found = 1'b0;
		// 0 behaves as a single frame, anything past the store as the full store
		lim = frame_limit;
		if (lim < 1)
			lim = 1;
		if (lim > FRAME_SLOTS)
			lim = FRAME_SLOTS;

		for (int unsigned j = 0; j < slots_filled; j++) begin
			if (!found && resident_page[j] == pg) begin
				found  = 1'b1;
				r.slot = SLOT_W'(j);
			end
		end

		if (found) begin
			r.hit = 1'b1;
			promote_slot(r.slot, resident_rank[r.slot]);
		end else begin
			if (faults_so_far != TOTAL_MAX)
				faults_so_far++;
			if (slots_filled < lim) begin
				// room left under the limit: take the next empty slot
				r.slot = SLOT_W'(slots_filled);
				slots_filled++;
				resident_page[r.slot] = pg;
				promote_slot(r.slot, slots_filled);
			end else begin
				// replace the oldest filled slot; strict compare keeps the
				// lowest slot when ranks tie (only with one frame filled)
				oldest = 0;
				r.slot = '0;
				for (int unsigned j = 0; j < slots_filled; j++) begin
					if (resident_rank[j] > oldest) begin
						oldest = resident_rank[j];
						r.slot = SLOT_W'(j);
					end
				end
				r.evicted_valid       = 1'b1;
				r.evicted_page        = resident_page[r.slot];
				resident_page[r.slot] = pg;
				promote_slot(r.slot, slots_filled);
			end
		end
		r.fault_total = faults_so_far;
		return r;
	endfunction

	// Sender gap: mostly none or short, now and then long. Dense phases
	// never leave a gap.
	function automatic int unsigned pick_gap(input bit dense);
		int unsigned roll;
		if (dense)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one page reference after an optional gap and wait for it to be
	// taken. With no gap, valid is simply left high from the previous item
	// so it is never dropped and raised in the same step.
	task automatic send_page(input page_t pg, input int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		page     <= pg;
		do @(posedge clk); while (!in_ready);
		pending_lookups = {pending_lookups, predict_lookup(pg)};
		refs_sent++;
	endtask

	// Stop offering items, let every outstanding result drain, then give the
	// block time to get back to idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write frame_count while the block is idle.
	task automatic set_frame_limit(input logic [FC_W-1:0] value);
		settle();
		frame_count_we    <= 1'b1;
		frame_count_wdata <= value;
		@(posedge clk);
		frame_count_we    <= 1'b0;
		frame_limit        = value;
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Limit of zero acts as one frame: fill, hit, replace slot 0 on every fault.
	task automatic test_single_frame();
		set_frame_limit(4'd0);
		send_page(16'h0000, pick_gap(1'b0));
		send_page(16'h0000, pick_gap(1'b0));
		send_page(16'hFFFF, pick_gap(1'b0));
		send_page(16'hFFFF, pick_gap(1'b0));
	endtask

	// Raising the limit lets faults fill empty slots again, then replacement
	// picks the least recent one.
	task automatic test_raise_limit();
		set_frame_limit(4'd3);
		send_page(16'hAAAA, pick_gap(1'b0));
		send_page(16'h5555, pick_gap(1'b0));
		send_page(16'hFFFF, pick_gap(1'b0));
		send_page(16'h1234, pick_gap(1'b0));
	endtask

	// Limit above the store acts as the full store: fill every slot, hit,
	// then evict the oldest of eight.
	task automatic test_full_store();
		set_frame_limit(4'd15);
		send_page(16'h0001, pick_gap(1'b0));
		send_page(16'h0002, pick_gap(1'b0));
		send_page(16'h0004, pick_gap(1'b0));
		send_page(16'h8000, pick_gap(1'b0));
		send_page(16'h7FFF, pick_gap(1'b0));
		send_page(16'h5555, pick_gap(1'b0));
		send_page(16'h0100, pick_gap(1'b0));
	endtask

	// Lowering the limit under the fill count empties nothing; faults replace
	// the oldest among all filled slots.
	task automatic test_lower_limit();
		set_frame_limit(4'd2);
		send_page(16'h0200, pick_gap(1'b0));
		send_page(16'h0400, pick_gap(1'b0));
		send_page(16'h0200, pick_gap(1'b0));
	endtask

	// ------------------------------------------------------------------
	// Random references. Each phase sets a limit and works on a small
	// random working set so hits and evictions both stay frequent; a tenth
	// of the references are fully random pages. Some phases run with no
	// sender gaps, and now and then the sender waits for a full drain.
	// ------------------------------------------------------------------
	task automatic test_random_refs();
		logic [FC_W-1:0] phase_limits [12] = '{4'd1, 4'd8, 4'd4, 4'd0, 4'd15, 4'd2,
		                                       4'd7, 4'd3, 4'd5, 4'd6, 4'd8, 4'd1};
		page_t           working_set [$];
		int unsigned     set_size;
		bit              dense;
		foreach (phase_limits[p]) begin
			set_frame_limit(phase_limits[p]);
			set_size = $urandom_range(3, 12);
			working_set.delete();
			repeat (set_size)
				working_set = {working_set, page_t'($urandom)};
			dense = ($urandom_range(0, 2) == 0);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 59) == 0)
					settle();
				// drift the working set slowly
				if ($urandom_range(0, 49) == 0)
					working_set[$urandom_range(0, set_size - 1)] = page_t'($urandom);
				if ($urandom_range(0, 9) == 0)
					send_page(page_t'($urandom), pick_gap(dense));
				else
					send_page(working_set[$urandom_range(0, set_size - 1)], pick_gap(dense));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side back-pressure: short ready/stall runs, occasional long
	// stalls, and long stretches with ready held high.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 10) begin
				out_ready  <= 1'b1;
				ready_hold  = $urandom_range(100, 300);
			end else if (ready_roll < 55) begin
				out_ready  <= 1'b1;
				ready_hold  = $urandom_range(0, 6);
			end else if (ready_roll < 95) begin
				out_ready  <= 1'b0;
				ready_hold  = $urandom_range(0, 2);
			end else begin
				out_ready  <= 1'b0;
				ready_hold  = $urandom_range(15, 50);
			end
		end
	end

	// Result checker: every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got_lookup = {hit, slot, evicted_valid, evicted_page, fault_total};
			results_seen++;
			hits_seen   += got_lookup.hit;
			evicts_seen += got_lookup.evicted_valid;
			if (pending_lookups.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_MAX)
					$display("%0t: result with nothing outstanding: hit=%0b slot=%0d ev=%0b evp=%h total=%0d",
						$realtime, hit, slot, evicted_valid, evicted_page, fault_total);
			end else begin
				want_lookup = pending_lookups.pop_front();
				if (got_lookup !== want_lookup) begin
					bad_results++;
					if (bad_results <= REPORT_MAX)
						$display("%0t: mismatch on result %0d: hit %0b/%0b slot %0d/%0d ev %0b/%0b evp %h/%h total %0d/%0d (exp/act)",
							$realtime, results_seen,
							want_lookup.hit, got_lookup.hit,
							want_lookup.slot, got_lookup.slot,
							want_lookup.evicted_valid, got_lookup.evicted_valid,
							want_lookup.evicted_page, got_lookup.evicted_page,
							want_lookup.fault_total, got_lookup.fault_total);
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_lookups.size());
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_single_frame();
		test_raise_limit();
		test_full_store();
		test_lower_limit();
		test_random_refs();

		// drain everything, then wait for stray results
		settle();

		$display("summary: %0d page references, %0d results checked, %0d hits, %0d evictions",
			refs_sent, results_seen, hits_seen, evicts_seen);
		$display("summary: frame limits 0 to 8 and 15 exercised, %0d faults counted, %0d bad results",
			faults_so_far, bad_results);
		if (bad_results == 0 && pending_lookups.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
